/* rtl/v210pp_pkg.sv */
// shared types and constants for the v210 pixel packer
package v210pp_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int FRAC_BITS   = SAMPLE_BITS - 2;
   localparam int CODE_BITS   = 10;
   localparam int SCALE_BITS  = 10;
   localparam int WORD_BITS   = 3 * CODE_BITS;
   localparam int CLAMP_BITS  = FRAC_BITS + 1;
   localparam int PROD_BITS   = CLAMP_BITS + SCALE_BITS;
   localparam int GROUP_WORDS = 4;
   localparam int GROUP_CODES = 12;
   localparam int CODE_IDX_BITS = 4;
   localparam int WORD_IDX_BITS = 4;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [SAMPLE_BITS-1:0] ONE_VAL    = SAMPLE_BITS'(1) << FRAC_BITS;
   localparam logic [SAMPLE_BITS-1:0] BIAS_RESET = SAMPLE_BITS'(1) << (FRAC_BITS - 1);
   localparam logic [PROD_BITS-1:0]   HALF_VAL   = PROD_BITS'(1) << (FRAC_BITS - 1);
   localparam logic [SCALE_BITS-1:0]  SCALE_RESET = 10'd1023;

   // register index taken from paddr[2]
   localparam logic REG_CHROMA_BIAS = 1'b0;
   localparam logic REG_CODE_SCALE  = 1'b1;

   // pixel position inside a six-pixel group
   localparam logic [2:0] PHASE_FIRST = 3'd0;
   localparam logic [2:0] PHASE_LAST  = 3'd5;

   // slot bases in the group code store
   localparam logic [CODE_IDX_BITS-1:0] SLOT_CB = 4'd6;
   localparam logic [CODE_IDX_BITS-1:0] SLOT_CR = 4'd9;

   localparam logic [WORD_IDX_BITS-1:0] GROUP_LAST_IDX = 4'd3;

   typedef struct packed {
      logic [2:0] phase;
      logic       last;
   } item_ctl_type;

   typedef struct packed {
      logic [GROUP_WORDS-1:0][WORD_BITS-1:0] words;
      logic [WORD_IDX_BITS-1:0]              last_idx;
      logic                                  line_end;
   } emit_load_type;

endpackage

/* rtl/v210pp_lane.sv */
// one conversion lane: bias, clamp to 0..1.0, scale, round half up to a 10-bit code
module v210pp_lane (
   input  logic                                clock,
   input  logic                                load,
   input  logic [v210pp_pkg::SAMPLE_BITS-1:0]  sample,
   input  logic [v210pp_pkg::SAMPLE_BITS-1:0]  bias,
   input  logic [v210pp_pkg::SCALE_BITS-1:0]   scale,
   output logic [v210pp_pkg::CODE_BITS-1:0]    code
);
   import v210pp_pkg::*;

   logic signed [SAMPLE_BITS:0] sum;
   logic [CLAMP_BITS-1:0]       clamped;
   logic [PROD_BITS-1:0]        prod_in;
   logic [PROD_BITS-1:0]        prod_ff;
   logic [PROD_BITS-1:0]        rounded;

   always_comb begin
      sum = $signed({sample[SAMPLE_BITS-1], sample}) + $signed({bias[SAMPLE_BITS-1], bias});
      if (sum[SAMPLE_BITS]) begin
         clamped = '0;
      end else if (sum[SAMPLE_BITS-1:0] > ONE_VAL) begin
         clamped = ONE_VAL[CLAMP_BITS-1:0];
      end else begin
         clamped = sum[CLAMP_BITS-1:0];
      end
      prod_in = PROD_BITS'(clamped) * PROD_BITS'(scale);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prod_ff <= prod_in;
      end
   end

   assign rounded = prod_ff + HALF_VAL;
   assign code    = rounded[FRAC_BITS+CODE_BITS-1:FRAC_BITS];

endmodule

/* rtl/v210pp_merge.sv */
// merge stage: collects lane codes into the group store and builds the four v210 words
module v210pp_merge (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              commit,
   input  v210pp_pkg::item_ctl_type          ctl,
   input  logic [v210pp_pkg::CODE_BITS-1:0]  luma_code,
   input  logic [v210pp_pkg::CODE_BITS-1:0]  cb_code,
   input  logic [v210pp_pkg::CODE_BITS-1:0]  cr_code,
   output logic                              emit,
   output v210pp_pkg::emit_load_type         load_data
);
   import v210pp_pkg::*;

   logic [GROUP_CODES-1:0][CODE_BITS-1:0] codes_ff;
   logic [GROUP_CODES-1:0][CODE_BITS-1:0] codes_in;
   logic [GROUP_CODES-1:0][CODE_BITS-1:0] merged;
   logic [1:0]                            groups_ff;
   logic [1:0]                            groups_in;
   logic [1:0]                            groups_next;
   logic [1:0]                            pair;

   assign emit        = (ctl.phase == PHASE_LAST) || ctl.last;
   assign pair        = ctl.phase[2:1];
   assign groups_next = groups_ff + 2'd1;

   always_comb begin
      merged = codes_ff;
      merged[CODE_IDX_BITS'(ctl.phase)] = luma_code;
      if (!ctl.phase[0]) begin
         merged[SLOT_CB + CODE_IDX_BITS'(pair)] = cb_code;
         merged[SLOT_CR + CODE_IDX_BITS'(pair)] = cr_code;
      end
   end

   always_comb begin
      load_data.words[0] = {merged[9],  merged[0],  merged[6]};
      load_data.words[1] = {merged[2],  merged[7],  merged[1]};
      load_data.words[2] = {merged[8],  merged[3],  merged[10]};
      load_data.words[3] = {merged[5],  merged[11], merged[4]};
      load_data.line_end = ctl.last;
      // padding up to a multiple of four groups: last index = 4*((4-g) mod 4) + 3
      if (ctl.last) begin
         load_data.last_idx = {2'(2'd0 - groups_next), 2'b11};
      end else begin
         load_data.last_idx = GROUP_LAST_IDX;
      end
   end

   always_comb begin
      codes_in  = codes_ff;
      groups_in = groups_ff;
      if (commit) begin
         if (emit) begin
            codes_in  = '0;
            groups_in = ctl.last ? 2'd0 : groups_next;
         end else begin
            codes_in = merged;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         codes_ff  <= '0;
         groups_ff <= '0;
      end else begin
         codes_ff  <= codes_in;
         groups_ff <= groups_in;
      end
   end

endmodule

/* rtl/v210pp_emit.sv */
// output sequencer: plays out a group's four words and any line padding, one beat per cycle unless rsp_stall holds it
module v210pp_emit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              load,
   input  v210pp_pkg::emit_load_type         load_data,
   input  logic                              rsp_stall,
   output logic                              busy,
   output logic                              rsp_valid,
   output logic [v210pp_pkg::WORD_BITS-1:0]  rsp_packed_word,
   output logic                              rsp_line_done
);
   import v210pp_pkg::*;

   logic                                  busy_ff;
   logic                                  busy_in;
   logic [WORD_IDX_BITS-1:0]              idx_ff;
   logic [WORD_IDX_BITS-1:0]              idx_in;
   logic [WORD_IDX_BITS-1:0]              last_idx_ff;
   logic                                  line_ff;
   logic [GROUP_WORDS-1:0][WORD_BITS-1:0] words_ff;
   logic                                  beat;
   logic                                  final_word;

   assign beat       = busy_ff && !rsp_stall;
   assign final_word = (idx_ff == last_idx_ff);

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (load) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (beat) begin
         if (final_word) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         words_ff    <= load_data.words;
         last_idx_ff <= load_data.last_idx;
         line_ff     <= load_data.line_end;
      end
   end

   assign busy            = busy_ff;
   assign rsp_valid       = busy_ff;
   // words past the group are padding
   assign rsp_packed_word = (idx_ff[WORD_IDX_BITS-1:2] == '0) ? words_ff[idx_ff[1:0]] : '0;
   assign rsp_line_done   = line_ff && final_word;

endmodule

/* rtl/v210_pixel_packer_top.sv */
// v210 pixel packer: 4:2:2 fixed-point pixels in, 30-bit v210 words out
//
// One pixel enters per req_ beat (luma, Cb, Cr, line_last); Cb and Cr are taken on
// even pixels of each six-pixel group only. Three conversion lanes turn the samples
// into 10-bit codes in parallel, a merge stage gathers them into the group store,
// and an output sequencer sends the four words of each group on the rsp_ channel.
// At line_last a partial group is flushed with missing codes zero, then zero words
// pad the line to a multiple of 16 words; rsp_line_done marks the final word.
// The first word of a group leaves once its last pixel has passed stage 1 (the lane
// registers) and been loaded into the sequencer. Throughput: one pixel per cycle
// while the sequencer keeps pace (4 words per 6 pixels); a group that completes
// while the sequencer is still sending the previous one holds req_stall until the
// sequencer is free, so padding at line end can stall the input.
// rsp_stall simply holds the current word; the pipeline fills and then stalls req_.
// Reset (synchronous) clears the group store and counters and sets chroma_bias to
// 0.5 and code_scale to 1023. Registers via the csr_ port: chroma_bias at 0x0,
// code_scale at 0x4; write them only while the block is idle.
module v210_pixel_packer_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [v210pp_pkg::SAMPLE_BITS-1:0]     req_luma,
   input  logic [v210pp_pkg::SAMPLE_BITS-1:0]     req_chroma_blue,
   input  logic [v210pp_pkg::SAMPLE_BITS-1:0]     req_chroma_red,
   input  logic                                   req_line_last,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [v210pp_pkg::WORD_BITS-1:0]       rsp_packed_word,
   output logic                                   rsp_line_done,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [v210pp_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [v210pp_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [v210pp_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                   csr_pready
);
   import v210pp_pkg::*;

   logic [SAMPLE_BITS-1:0] bias_ff;
   logic [SCALE_BITS-1:0]  scale_ff;
   logic                   csr_write;

   logic                   accept;
   logic [2:0]             phase_ff;
   logic [2:0]             phase_in;
   logic                   s1_valid_ff;
   item_ctl_type           s1_ctl_ff;
   logic                   s1_adv;
   logic                   commit;
   logic                   emit;
   logic                   emit_busy;
   emit_load_type          load_data;

   logic [CODE_BITS-1:0]   luma_code;
   logic [CODE_BITS-1:0]   cb_code;
   logic [CODE_BITS-1:0]   cr_code;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         bias_ff  <= BIAS_RESET;
         scale_ff <= SCALE_RESET;
      end else if (csr_write) begin
         case (csr_paddr[2])
            REG_CHROMA_BIAS: bias_ff  <= csr_pwdata[SAMPLE_BITS-1:0];
            REG_CODE_SCALE:  scale_ff <= csr_pwdata[SCALE_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_CHROMA_BIAS: csr_prdata = {{(CSR_DATA_BITS-SAMPLE_BITS){bias_ff[SAMPLE_BITS-1]}},
                                        bias_ff};
         REG_CODE_SCALE:  csr_prdata = CSR_DATA_BITS'(scale_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // a group end waits in stage 1 until the sequencer is free
   assign s1_adv    = !s1_valid_ff || !emit || !emit_busy;
   assign req_stall = !s1_adv;
   assign accept    = req_valid && !req_stall;
   assign commit    = s1_valid_ff && s1_adv;

   assign phase_in = (phase_ff == PHASE_LAST || req_line_last) ? PHASE_FIRST
                                                               : phase_ff + 3'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PHASE_FIRST;
         s1_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff <= phase_in;
         end
         if (s1_adv) begin
            s1_valid_ff <= accept;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ctl_ff.phase <= phase_ff;
         s1_ctl_ff.last  <= req_line_last;
      end
   end

   v210pp_lane u_lane_luma (
      .clock  (clock),
      .load   (accept),
      .sample (req_luma),
      .bias   ('0),
      .scale  (scale_ff),
      .code   (luma_code)
   );

   v210pp_lane u_lane_cb (
      .clock  (clock),
      .load   (accept),
      .sample (req_chroma_blue),
      .bias   (bias_ff),
      .scale  (scale_ff),
      .code   (cb_code)
   );

   v210pp_lane u_lane_cr (
      .clock  (clock),
      .load   (accept),
      .sample (req_chroma_red),
      .bias   (bias_ff),
      .scale  (scale_ff),
      .code   (cr_code)
   );

   v210pp_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .commit    (commit),
      .ctl       (s1_ctl_ff),
      .luma_code (luma_code),
      .cb_code   (cb_code),
      .cr_code   (cr_code),
      .emit      (emit),
      .load_data (load_data)
   );

   v210pp_emit u_emit (
      .clock           (clock),
      .reset           (reset),
      .load            (commit && emit),
      .load_data       (load_data),
      .rsp_stall       (rsp_stall),
      .busy            (emit_busy),
      .rsp_valid       (rsp_valid),
      .rsp_packed_word (rsp_packed_word),
      .rsp_line_done   (rsp_line_done)
   );

endmodule

/* bench/v210_pixel_packer_top_tb.sv */
// self-checking testbench for the v210 pixel packer with a line-level word scoreboard
`timescale 1ns / 100ps

import v210pp_pkg::*;

typedef struct packed {
   logic [WORD_BITS-1:0] word;
   logic                 done;
} v210_word_type;

class packed_line_scoreboard;
   logic signed [SAMPLE_BITS-1:0] bias;
   logic [SCALE_BITS-1:0]         scale;
   int unsigned                   phase;
   int unsigned                   group_count;
   logic [CODE_BITS-1:0]          codes [GROUP_CODES];
   logic [WORD_BITS-1:0]          burst [$];
   v210_word_type                 expected_words [$];
   int unsigned                   mismatches;
   int unsigned                   words_checked;
   int unsigned                   pixels_taken;
   int unsigned                   lines_taken;
   int unsigned                   reg_writes;

   function new();
      bias = BIAS_RESET;
      scale = SCALE_RESET;
      mismatches = 0;
      words_checked = 0;
      pixels_taken = 0;
      lines_taken = 0;
      reg_writes = 0;
      clear_line();
   endfunction

   function void clear_line();
      phase = 0;
      group_count = 0;
      foreach (codes[i]) codes[i] = '0;
   endfunction

   function void write_reg(logic idx, logic [CSR_DATA_BITS-1:0] data);
      case (idx)
         REG_CHROMA_BIAS: bias = data[SAMPLE_BITS-1:0];
         REG_CODE_SCALE:  scale = data[SCALE_BITS-1:0];
         default: ;
      endcase
      reg_writes++;
   endfunction

   // clamp to 0..1.0, scale, round half up
   function logic [CODE_BITS-1:0] sample_code(longint v);
      longint one_q;
      longint prod;
      one_q = longint'(1) << FRAC_BITS;
      if (v < 0) v = 0;
      if (v > one_q) v = one_q;
      prod = v * longint'(scale) + (longint'(1) << (FRAC_BITS - 1));
      return CODE_BITS'((prod >> FRAC_BITS) & 1023);
   endfunction

   function void flush_group();
      burst.push_back({codes[SLOT_CR], codes[0], codes[SLOT_CB]});
      burst.push_back({codes[2], codes[SLOT_CB + 1], codes[1]});
      burst.push_back({codes[SLOT_CB + 2], codes[3], codes[SLOT_CR + 1]});
      burst.push_back({codes[5], codes[SLOT_CR + 2], codes[4]});
      foreach (codes[i]) codes[i] = '0;
      group_count = (group_count + 1) % 4;
   endfunction

   function void note_pixel(logic [SAMPLE_BITS-1:0] luma, logic [SAMPLE_BITS-1:0] cb,
                            logic [SAMPLE_BITS-1:0] cr, logic last);
      int unsigned p;
      int unsigned pair;
      v210_word_type e;
      burst.delete();
      p = (phase > PHASE_LAST) ? PHASE_FIRST : phase;
      codes[p] = sample_code(longint'($signed(luma)));
      if (p % 2 == 0) begin
         pair = p / 2;
         codes[SLOT_CB + pair] = sample_code(longint'($signed(cb)) + longint'(bias));
         codes[SLOT_CR + pair] = sample_code(longint'($signed(cr)) + longint'(bias));
      end
      if (p == PHASE_LAST) begin
         flush_group();
         p = PHASE_FIRST;
      end else begin
         p++;
         if (last) flush_group();
      end
      if (last) begin
         // pad the line out to a multiple of 16 words
         if (group_count != 0) repeat ((4 - group_count) * 4) burst.push_back('0);
         clear_line();
         p = PHASE_FIRST;
         lines_taken++;
      end
      phase = p;
      foreach (burst[i]) begin
         e.word = burst[i];
         e.done = last && (i == burst.size() - 1);
         expected_words.push_back(e);
      end
      pixels_taken++;
   endfunction

   function void check_word(logic [WORD_BITS-1:0] word, logic done);
      v210_word_type e;
      if (expected_words.size() == 0) begin
         mismatches++;
         $display("%0t: word expected none, actual %h line_done %b", $time, word, done);
         return;
      end
      e = expected_words.pop_front();
      words_checked++;
      if (word !== e.word) begin
         mismatches++;
         $display("%0t: packed_word expected %h actual %h", $time, e.word, word);
      end
      if (done !== e.done) begin
         mismatches++;
         $display("%0t: line_done expected %b actual %b", $time, e.done, done);
      end
   endfunction
endclass

module v210_pixel_packer_top_tb;
   localparam int CYCLE_LIMIT = 600000;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [SAMPLE_BITS-1:0]   req_luma;
   logic [SAMPLE_BITS-1:0]   req_chroma_blue;
   logic [SAMPLE_BITS-1:0]   req_chroma_red;
   logic                     req_line_last;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic [WORD_BITS-1:0]     rsp_packed_word;
   logic                     rsp_line_done;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   packed_line_scoreboard sb;
   bit                    steady;
   int                    stall_left;
   int unsigned           cycle_count;

   v210_pixel_packer_top DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_luma        (req_luma),
      .req_chroma_blue (req_chroma_blue),
      .req_chroma_red  (req_chroma_red),
      .req_line_last   (req_line_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_packed_word (rsp_packed_word),
      .rsp_line_done   (rsp_line_done),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 2);
      if (r < 96) return $urandom_range(3, 6);
      return $urandom_range(12, 30);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) sb.check_word(rsp_packed_word, rsp_line_done);
         if (stall_left == 0 && !steady && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
            if (stall_left == 0) stall_left = 1;
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_pixel(input logic [SAMPLE_BITS-1:0] luma,
                             input logic [SAMPLE_BITS-1:0] cb,
                             input logic [SAMPLE_BITS-1:0] cr,
                             input logic last, input bit drop_after);
      int gap;
      req_valid <= 1'b1;
      req_luma <= luma;
      req_chroma_blue <= cb;
      req_chroma_red <= cr;
      req_line_last <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_pixel(luma, cb, cr, last);
      gap = pick_gap();
      // a dropped valid is held low before the next pixel is sent
      if (drop_after && gap == 0) gap = 1;
      if (drop_after || gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic csr_write(input logic idx, input logic [CSR_DATA_BITS-1:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      sb.write_reg(idx, data);
      @(posedge clock);
   endtask

   task automatic wait_idle();
      while (sb.expected_words.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_regs(input logic [SAMPLE_BITS-1:0] bias,
                           input logic [SCALE_BITS-1:0] scale);
      wait_idle();
      csr_write(REG_CHROMA_BIAS, {{(CSR_DATA_BITS - SAMPLE_BITS){bias[SAMPLE_BITS-1]}}, bias});
      csr_write(REG_CODE_SCALE, {{(CSR_DATA_BITS - SCALE_BITS){1'b0}}, scale});
   endtask

   function automatic logic [SAMPLE_BITS-1:0] rand_sample();
      logic [SAMPLE_BITS-1:0] corners [7];
      corners = '{16'h0000, 16'h4000, 16'h3FFF, 16'h4001, 16'h7FFF, 16'h8000, 16'hFFFF};
      case ($urandom_range(0, 3))
         0, 1: return SAMPLE_BITS'($urandom_range(0, 16'h4000));
         2: return SAMPLE_BITS'($urandom);
         default: return corners[$urandom_range(0, 6)];
      endcase
   endfunction

   task automatic run_lines(input int pixel_budget);
      int sent;
      int len;
      int r;
      bit final_line;
      sent = 0;
      while (sent < pixel_budget) begin
         r = $urandom_range(0, 9);
         // whole multiples of four groups need no padding
         if (r == 0) len = 24;
         else if (r == 1) len = 1;
         else if (r == 2) len = 6;
         else if (r == 3) len = $urandom_range(25, 48);
         else len = $urandom_range(2, 23);
         final_line = (sent + len >= pixel_budget);
         for (int i = 0; i < len; i++)
            send_pixel(rand_sample(), rand_sample(), rand_sample(), i == len - 1,
                       final_line && i == len - 1);
         sent += len;
      end
   endtask

   initial begin
      sb = new();
      steady = 1'b0;
      cycle_count = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_luma <= '0;
      req_chroma_blue <= '0;
      req_chroma_red <= '0;
      req_line_last <= 1'b0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // full group of extremes, odd pixels carry chroma that must be ignored
      send_pixel(16'h7FFF, 16'h8000, 16'h7FFF, 1'b0, 1'b0);
      send_pixel(16'h8000, 16'hAAAA, 16'h5555, 1'b0, 1'b0);
      send_pixel(16'h4000, 16'h0000, 16'hFFFF, 1'b0, 1'b0);
      send_pixel(16'h2000, 16'h1234, 16'h4321, 1'b0, 1'b0);
      send_pixel(16'h4001, 16'h2000, 16'hE000, 1'b0, 1'b0);
      send_pixel(16'hFFFF, 16'h7FFF, 16'h8000, 1'b0, 1'b0);
      // one-pixel partial group closes the line
      send_pixel(16'h0000, 16'h6000, 16'h2000, 1'b1, 1'b0);
      // single pixel line gives the longest burst
      send_pixel(16'h3FFF, 16'h3FFF, 16'hC000, 1'b1, 1'b0);
      // line that ends exactly on a group boundary
      for (int i = 0; i < 6; i++)
         send_pixel(SAMPLE_BITS'(16'h1000 * i), SAMPLE_BITS'(16'h0800 * i),
                    SAMPLE_BITS'(16'h3000 - 16'h0400 * i), i == 5, 1'b0);
      // three-pixel line
      send_pixel(16'h0001, 16'hC000, 16'h0001, 1'b0, 1'b0);
      send_pixel(16'h5555, 16'h5555, 16'hAAAA, 1'b0, 1'b0);
      send_pixel(16'h3000, 16'hF000, 16'h1000, 1'b1, 1'b1);
      run_lines(60);

      // unit scale with no bias exposes the round-half-up step
      set_regs(16'h0000, 10'd1);
      send_pixel(16'h2000, 16'h2000, 16'h1FFF, 1'b0, 1'b0);
      send_pixel(16'h1FFF, 16'h0000, 16'h0000, 1'b0, 1'b0);
      send_pixel(16'h6000, 16'h3FFF, 16'h4000, 1'b1, 1'b1);
      run_lines(50);

      set_regs(16'h8000, 10'd0);
      run_lines(50);
      set_regs(16'h7FFF, 10'd1023);
      run_lines(50);
      set_regs(SAMPLE_BITS'($urandom), SCALE_BITS'($urandom));
      steady = 1'b1;
      run_lines(50);
      steady = 1'b0;
      set_regs(BIAS_RESET, 10'd512);
      run_lines(50);

      wait_idle();
      repeat (16) @(posedge clock);
      $display("tb summary: %0d pixels in %0d lines, %0d words checked, %0d register writes",
               sb.pixels_taken, sb.lines_taken, sb.words_checked, sb.reg_writes);
      $display("tb summary: %0d mismatches", sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule

/* filelist.f */
rtl/v210pp_pkg.sv
rtl/v210pp_lane.sv
rtl/v210pp_merge.sv
rtl/v210pp_emit.sv
rtl/v210_pixel_packer_top.sv
bench/v210_pixel_packer_top_tb.sv
